// ===== sv/vmmn_pkg.sv =====
// Shared constants and controller/datapath interface types for the normalizer.
`timescale 1ns / 1ps

package vmmn_pkg;

  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int DATA_W           = 16;
  localparam int Q_BITS           = 16;
  localparam int STEP_W           = $clog2(Q_BITS);

  typedef struct packed {
    logic load;      // store the incoming sample, update min/max
    logic idx_clr;   // rewind the read index
    logic idx_inc;   // advance the read index
    logic div_init;  // load divider from the fetched sample
    logic div_step;  // one restoring-division step
    logic out_load;  // capture a result into the output register
    logic vec_clr;   // return min/max/count to reset values
  } cmd_t;

  typedef struct packed {
    logic vec_end;   // the request on the input ends the vector
    logic last_elem; // the element being emitted is the final one
    logic out_free;  // output register can take a new result
  } status_t;

endpackage

// ===== sv/vmmn_ctrl.sv =====
// Sequencing state machine: load, fetch, divide and emit.
`timescale 1ns / 1ps

module vmmn_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  vmmn_pkg::status_t status,
  output vmmn_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_FETCH = 5'b00010,
    S_INIT  = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  localparam logic [vmmn_pkg::STEP_W-1:0] STEP_LAST = vmmn_pkg::STEP_W'(vmmn_pkg::Q_BITS - 1);

  state_t                       state, state_next;
  logic [vmmn_pkg::STEP_W-1:0]  step, step_next;

  always_comb begin
    state_next = state;
    step_next  = '0;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (status.vec_end) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.last_elem) begin
            cmd.vec_clr = 1'b1;
            state_next  = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== sv/vmmn_datapath.sv =====
// Sample store, min/max tracking, serial divider and output register.
`timescale 1ns / 1ps

module vmmn_datapath #(
  parameter int MAX_ELEMENTS = vmmn_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vmmn_pkg::cmd_t               cmd,
  output vmmn_pkg::status_t            status,
  input  logic [vmmn_pkg::DATA_W-1:0]  s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [vmmn_pkg::Q_BITS-1:0]  m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);

  localparam int DW = vmmn_pkg::DATA_W;
  localparam int QW = vmmn_pkg::Q_BITS;
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic signed [DW-1:0] mem [MAX_ELEMENTS];
  logic signed [DW-1:0] rd_data;
  logic signed [DW-1:0] sample;
  logic signed [DW-1:0] running_min;
  logic signed [DW-1:0] running_max;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_inc;
  logic [AW-1:0]        rd_idx;
  logic [DW-1:0]        range_q;
  logic [DW:0]          range_diff;
  logic [DW:0]          shift_diff;
  logic [DW-1:0]        shifted;

  logic [DW-1:0]        rem;
  logic [QW-1:0]        quo;
  logic [DW-1:0]        feed;
  logic [DW:0]          trial;
  logic [DW:0]          trial_sub;
  logic                 trial_ge;

  assign sample    = signed'(s_tdata);
  assign count_inc = count + 1'b1;

  assign status.vec_end   = s_tlast || (count_inc == CW'(MAX_ELEMENTS));
  assign status.last_elem = ((CW'(rd_idx) + CW'(1)) == count);
  assign status.out_free  = !m_tvalid || m_tready;

  // Range and offset-corrected sample; both are non-negative and fit 16 bits.
  assign range_diff = {running_max[DW-1], running_max} - {running_min[DW-1], running_min};
  assign shift_diff = {rd_data[DW-1], rd_data} - {running_min[DW-1], running_min};
  assign shifted    = shift_diff[DW-1:0];

  // Restoring division of (shifted << 15) by range, one quotient bit per step.
  assign trial     = {rem, feed[DW-1]};
  assign trial_ge  = (trial >= {1'b0, range_q});
  assign trial_sub = trial - {1'b0, range_q};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[count[AW-1:0]] <= sample;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_min <= '0;
      running_max <= {1'b1, {(DW-1){1'b0}}};
      rd_idx      <= '0;
    end else begin
      if (cmd.load) begin
        count <= count_inc;
        if (sample < running_min) begin
          running_min <= sample;
        end
        if (sample > running_max) begin
          running_max <= sample;
        end
      end
      if (cmd.vec_clr) begin
        count       <= '0;
        running_min <= '0;
        running_max <= {1'b1, {(DW-1){1'b0}}};
      end
      if (cmd.idx_clr) begin
        rd_idx <= '0;
      end else if (cmd.idx_inc) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    range_q <= range_diff[DW-1:0];
    if (cmd.div_init) begin
      rem  <= {1'b0, shifted[DW-1:1]};
      feed <= {shifted[0], {(DW-1){1'b0}}};
      quo  <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      feed <= {feed[DW-2:0], 1'b0};
      quo  <= {quo[QW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= (range_q == '0) ? '0 : quo;
      m_tuser <= (range_q == '0);
      m_tlast <= status.last_elem;
    end
  end

  a_zero_range_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("div_zero result with nonzero value");

  a_min_not_positive: assert property (@(posedge clk) disable iff (rst)
    running_min[DW-1] || (running_min == '0))
    else $error("clamped minimum went positive");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMENTS))
    else $error("element count beyond store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending output");

endmodule

// ===== sv/vector_min_max_normalizer.sv =====
// After the last input request, each element passes in order through memory fetch, divider
// load, the 16-step serial divider and output capture, which waits until the output is free.
// Loading takes one sample per cycle while in the load state; no element overlaps the next.
// The next vector is accepted the cycle after the final result is captured.
// Reset (rst, synchronous, active high) clears the state machine, count, min/max and
// the output valid; the sample store is not cleared.
`timescale 1ns / 1ps

module vector_min_max_normalizer #(
  parameter int MAX_ELEMENTS = vmmn_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [vmmn_pkg::DATA_W-1:0]  s_tdata,   // [15:0] sample
  input  logic                         s_tlast,   // last_in
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [vmmn_pkg::Q_BITS-1:0]  m_tdata,   // [15:0] normalized
  output logic                         m_tuser,   // [0] div_zero
  output logic                         m_tlast    // last_out
);

  vmmn_pkg::cmd_t    cmd;
  vmmn_pkg::status_t status;

  vmmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  vmmn_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
